@@ design/ucfq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ucfq_pkg
// shared types, constants and helpers of the uart command framer queue
// ----------------------------------------------------------------------------
package ucfq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int BYTE_W  = 8;
  localparam int WORD_W  = 16;
  localparam int REM_W   = 4;
  localparam int TICK_W  = 16;
  localparam int READY_W = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [REM_W-1:0] LEN_CALIBRATE = 4'd12;
  localparam logic [REM_W-1:0] LEN_THRESHOLD = 4'd4;
  localparam logic [REM_W-1:0] LEN_BUTTONS   = 4'd12;
  localparam logic [REM_W-1:0] LEN_INTERRUPT = 4'd3;

  localparam logic [READY_W-1:0] READY_MAX = 8'hFF;

  localparam logic [BYTE_W-1:0] RST_CODE_CALIBRATE  = 8'd1;
  localparam logic [BYTE_W-1:0] RST_CODE_THRESHOLD  = 8'd2;
  localparam logic [BYTE_W-1:0] RST_CODE_BUTTONS    = 8'd3;
  localparam logic [BYTE_W-1:0] RST_CODE_INTERRUPT  = 8'd4;
  localparam logic [BYTE_W-1:0] RST_CODE_LEVEL_READ = 8'd5;
  localparam logic [TICK_W-1:0] RST_TIMEOUT_TICKS   = 16'd1000;

  typedef enum logic [1:0] {
    ACT_RX       = 2'd0,
    ACT_TICK     = 2'd1,
    ACT_POP_BYTE = 2'd2,
    ACT_POP_WORD = 2'd3
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CODE_CALIBRATE  = 3'd0,
    REG_CODE_THRESHOLD  = 3'd1,
    REG_CODE_BUTTONS    = 3'd2,
    REG_CODE_INTERRUPT  = 3'd3,
    REG_CODE_LEVEL_READ = 3'd4,
    REG_TIMEOUT_TICKS   = 3'd5
  } cfg_reg_e;

  // controller to datapath
  typedef struct packed {
    logic exec;      // apply a received byte or a tick
    logic pop;       // read one byte and advance the read side
    logic save_lo;   // keep the low byte of a word pop
    logic out_plain; // load a result without popped data
    logic out_byte;  // load a byte pop result
    logic out_word;  // load a word pop result
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic has_one;
    logic has_two;
  } dp_status_t;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] nxt;
    nxt = (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
    return nxt;
  endfunction

endpackage
`default_nettype wire

@@ design/uart_command_framer_queue.sv @@
// received byte, tick or short pop: registered result next cycle, one per cycle if not stalled
// byte pop: loaded in S_BYTE, word pop: S_WORD then S_HIGH (one queue ram read per cycle)
// a new transaction is taken once the previous pop has finished and the result slot frees
// reset: framing, counters, timer and pointers cleared, codes and timeout to defaults
// queue ram contents are undefined after reset and need no clearing pass
`default_nettype none
// ----------------------------------------------------------------------------
// uart_command_framer_queue
// frames uart commands into a byte queue drained by host pops
// ----------------------------------------------------------------------------
module uart_command_framer_queue (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [1:0]                     action_i,
  input  wire logic [ucfq_pkg::BYTE_W-1:0]    rx_byte_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic      [ucfq_pkg::WORD_W-1:0]    read_data_o,
  output logic                                read_ok_o,
  output logic      [ucfq_pkg::READY_W-1:0]   frames_ready_o,
  output logic                                receiving_o,
  output logic      [ucfq_pkg::CNT_W-1:0]     queue_count_o,
  output logic                                timed_out_o,
  output logic                                byte_dropped_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [ucfq_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [ucfq_pkg::TICK_W-1:0]    cfg_data_i
);

  import ucfq_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  ucfq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  ucfq_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .action_i       (action_i),
    .rx_byte_i      (rx_byte_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .read_data_o    (read_data_o),
    .read_ok_o      (read_ok_o),
    .frames_ready_o (frames_ready_o),
    .receiving_o    (receiving_o),
    .queue_count_o  (queue_count_o),
    .timed_out_o    (timed_out_o),
    .byte_dropped_o (byte_dropped_o)
  );

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (queue_count_o <= CNT_W'(QUEUE_DEPTH)))
    else $error("queue count beyond depth");

  a_timeout_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && timed_out_o) |->
      (queue_count_o == '0 && frames_ready_o == '0 && !receiving_o && !byte_dropped_o))
    else $error("timeout result did not clear framing");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !read_ok_o) |-> (read_data_o == '0))
    else $error("failed pop returned data");

  a_single_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.exec, cmd.pop}) && $onehot0({cmd.out_plain, cmd.out_byte, cmd.out_word}))
    else $error("conflicting datapath commands");

endmodule
`default_nettype wire

@@ design/ucfq_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ucfq_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module ucfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ design/ucfq_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ucfq_dp
// framing state, queue pointers, timer, configuration and result register
// ----------------------------------------------------------------------------
module ucfq_dp (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire ucfq_pkg::ctrl_cmd_t            cmd_i,
  output ucfq_pkg::dp_status_t                status_o,
  input  wire logic [1:0]                     action_i,
  input  wire logic [ucfq_pkg::BYTE_W-1:0]    rx_byte_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [ucfq_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [ucfq_pkg::TICK_W-1:0]    cfg_data_i,
  output logic      [ucfq_pkg::WORD_W-1:0]    read_data_o,
  output logic                                read_ok_o,
  output logic      [ucfq_pkg::READY_W-1:0]   frames_ready_o,
  output logic                                receiving_o,
  output logic      [ucfq_pkg::CNT_W-1:0]     queue_count_o,
  output logic                                timed_out_o,
  output logic                                byte_dropped_o
);

  import ucfq_pkg::*;

  logic [BYTE_W-1:0]  code_cal_q, code_thr_q, code_btn_q, code_int_q, code_lvl_q;
  logic [TICK_W-1:0]  timeout_q;

  logic [IDX_W-1:0]   wr_idx_q, wr_idx_d;
  logic [IDX_W-1:0]   rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0]   held_q, held_d;
  logic               in_payload_q, in_payload_d;
  logic [REM_W-1:0]   rem_q, rem_d;
  logic [READY_W-1:0] ready_q, ready_d;
  logic               tmr_run_q, tmr_run_d;
  logic [TICK_W-1:0]  tmr_q, tmr_d;

  logic [BYTE_W-1:0]  lo_q;
  logic [WORD_W-1:0]  rdata_q;
  logic               rok_q, tout_q, drop_q;
  logic [READY_W-1:0] ready_out_q;
  logic               recv_q;
  logic [CNT_W-1:0]   cnt_q;

  logic               push;
  logic               tout, drop;
  logic               full;
  logic [REM_W-1:0]   len;
  logic [REM_W-1:0]   rem_dec;
  logic [TICK_W-1:0]  tmr_inc;
  logic [READY_W-1:0] ready_bump;
  logic [BYTE_W-1:0]  ram_rdata;

  assign full       = (held_q >= CNT_W'(QUEUE_DEPTH));
  assign rem_dec    = rem_q - 1'b1;
  assign tmr_inc    = tmr_q + 1'b1;
  assign ready_bump = (ready_q != READY_MAX) ? ready_q + 1'b1 : ready_q;

  always_comb begin
    priority if (rx_byte_i == code_cal_q) len = LEN_CALIBRATE;
    else if (rx_byte_i == code_thr_q)     len = LEN_THRESHOLD;
    else if (rx_byte_i == code_btn_q)     len = LEN_BUTTONS;
    else if (rx_byte_i == code_int_q)     len = LEN_INTERRUPT;
    else                                  len = '0;
  end

  always_comb begin
    wr_idx_d     = wr_idx_q;
    rd_idx_d     = rd_idx_q;
    held_d       = held_q;
    in_payload_d = in_payload_q;
    rem_d        = rem_q;
    ready_d      = ready_q;
    tmr_run_d    = tmr_run_q;
    tmr_d        = tmr_q;
    push         = 1'b0;
    tout         = 1'b0;
    drop         = 1'b0;

    if (cmd_i.exec) begin
      unique case (action_e'(action_i))
        ACT_RX: begin
          if (in_payload_q) begin
            tmr_d = '0;
            if (full) begin
              drop = 1'b1;
            end else begin
              push  = 1'b1;
              rem_d = rem_dec;
              if (rem_dec == '0) begin
                tmr_run_d    = 1'b0;
                in_payload_d = 1'b0;
                ready_d      = ready_bump;
              end
            end
          end else if (len != '0) begin
            if (full) begin
              drop = 1'b1;
            end else begin
              push         = 1'b1;
              in_payload_d = 1'b1;
              rem_d        = len;
              tmr_d        = '0;
              tmr_run_d    = 1'b1;
            end
          end else if (rx_byte_i == code_lvl_q) begin
            ready_d = ready_bump;
          end else begin
            drop = 1'b1;
          end
        end
        ACT_TICK: begin
          if (tmr_run_q) begin
            tmr_d = tmr_inc;
            if (tmr_inc >= timeout_q) begin
              tmr_run_d    = 1'b0;
              tmr_d        = '0;
              in_payload_d = 1'b0;
              rem_d        = '0;
              ready_d      = '0;
              tout         = 1'b1;
            end
          end
        end
        ACT_POP_BYTE, ACT_POP_WORD: begin
        end
        default: begin
        end
      endcase
    end

    if (push) begin
      wr_idx_d = next_idx(wr_idx_q);
      held_d   = held_q + 1'b1;
    end
    if (cmd_i.pop) begin
      rd_idx_d = next_idx(rd_idx_q);
      held_d   = held_q - 1'b1;
    end
    if (tout) begin
      wr_idx_d = '0;
      rd_idx_d = '0;
      held_d   = '0;
    end
  end

  ucfq_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (wr_idx_q),
    .wdata_i (rx_byte_i),
    .re_i    (cmd_i.pop),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_cal_q   <= RST_CODE_CALIBRATE;
      code_thr_q   <= RST_CODE_THRESHOLD;
      code_btn_q   <= RST_CODE_BUTTONS;
      code_int_q   <= RST_CODE_INTERRUPT;
      code_lvl_q   <= RST_CODE_LEVEL_READ;
      timeout_q    <= RST_TIMEOUT_TICKS;
      wr_idx_q     <= '0;
      rd_idx_q     <= '0;
      held_q       <= '0;
      in_payload_q <= 1'b0;
      rem_q        <= '0;
      ready_q      <= '0;
      tmr_run_q    <= 1'b0;
      tmr_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_CODE_CALIBRATE:  code_cal_q <= cfg_data_i[BYTE_W-1:0];
          REG_CODE_THRESHOLD:  code_thr_q <= cfg_data_i[BYTE_W-1:0];
          REG_CODE_BUTTONS:    code_btn_q <= cfg_data_i[BYTE_W-1:0];
          REG_CODE_INTERRUPT:  code_int_q <= cfg_data_i[BYTE_W-1:0];
          REG_CODE_LEVEL_READ: code_lvl_q <= cfg_data_i[BYTE_W-1:0];
          REG_TIMEOUT_TICKS:   timeout_q  <= cfg_data_i;
          default: begin
          end
        endcase
      end
      wr_idx_q     <= wr_idx_d;
      rd_idx_q     <= rd_idx_d;
      held_q       <= held_d;
      in_payload_q <= in_payload_d;
      rem_q        <= rem_d;
      ready_q      <= ready_d;
      tmr_run_q    <= tmr_run_d;
      tmr_q        <= tmr_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.save_lo) begin
      lo_q <= ram_rdata;
    end
    if (cmd_i.out_plain || cmd_i.out_byte || cmd_i.out_word) begin
      priority if (cmd_i.out_word) begin
        rdata_q <= {ram_rdata, lo_q};
        rok_q   <= 1'b1;
      end else if (cmd_i.out_byte) begin
        rdata_q <= {{(WORD_W-BYTE_W){1'b0}}, ram_rdata};
        rok_q   <= 1'b1;
      end else begin
        rdata_q <= '0;
        rok_q   <= 1'b0;
      end
      tout_q      <= tout;
      drop_q      <= drop;
      ready_out_q <= ready_d;
      recv_q      <= in_payload_d;
      cnt_q       <= held_d;
    end
  end

  assign status_o.has_one = (held_q >= CNT_W'(1));
  assign status_o.has_two = (held_q >= CNT_W'(2));

  assign read_data_o    = rdata_q;
  assign read_ok_o      = rok_q;
  assign frames_ready_o = ready_out_q;
  assign receiving_o    = recv_q;
  assign queue_count_o  = cnt_q;
  assign timed_out_o    = tout_q;
  assign byte_dropped_o = drop_q;

endmodule
`default_nettype wire

@@ design/ucfq_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ucfq_ctrl
// transaction control: accepts items, sequences queue reads, owns result valid
// ----------------------------------------------------------------------------
module ucfq_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [1:0]           action_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output ucfq_pkg::ctrl_cmd_t       cmd_o,
  input  wire ucfq_pkg::dp_status_t status_i
);

  import ucfq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BYTE,
    S_WORD,
    S_HIGH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_free;
  logic   load;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) && out_free);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (action_e'(action_i))
            ACT_RX, ACT_TICK: begin
              cmd_o.exec      = 1'b1;
              cmd_o.out_plain = 1'b1;
            end
            ACT_POP_BYTE: begin
              if (status_i.has_one) begin
                cmd_o.pop = 1'b1;
                state_d   = S_BYTE;
              end else begin
                cmd_o.out_plain = 1'b1;
              end
            end
            ACT_POP_WORD: begin
              if (status_i.has_two) begin
                cmd_o.pop = 1'b1;
                state_d   = S_WORD;
              end else begin
                cmd_o.out_plain = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_BYTE: begin
        cmd_o.out_byte = 1'b1;
        state_d        = S_IDLE;
      end
      S_WORD: begin
        cmd_o.save_lo = 1'b1;
        cmd_o.pop     = 1'b1;
        state_d       = S_HIGH;
      end
      S_HIGH: begin
        cmd_o.out_word = 1'b1;
        state_d        = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign load = cmd_o.out_plain || cmd_o.out_byte || cmd_o.out_word;

  always_comb begin
    priority if (load)            out_valid_d = 1'b1;
    else if (!out_stall_i)        out_valid_d = 1'b0;
    else                          out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart command framer queue testbench
// drives received bytes, ticks and host pops with random gaps and output
// stalls, and checks every result against a cycle-free framer tracker
// ----------------------------------------------------------------------------
module tb;
  import ucfq_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0]  read_data;
    logic               read_ok;
    logic [READY_W-1:0] frames_ready;
    logic               receiving;
    logic [CNT_W-1:0]   queue_count;
    logic               timed_out;
    logic               byte_dropped;
  } framer_status_t;

  class framer_tracker;
    logic [BYTE_W-1:0]  codes [5];
    logic [TICK_W-1:0]  timeout;
    logic [BYTE_W-1:0]  store [QUEUE_DEPTH];
    logic [IDX_W-1:0]   wr_ptr;
    logic [IDX_W-1:0]   rd_ptr;
    int                 held;
    bit                 in_frame;
    logic [REM_W-1:0]   remaining;
    logic [READY_W-1:0] ready;
    bit                 timer_on;
    logic [TICK_W-1:0]  timer;
    framer_status_t     pending_status [$];
    int                 errors;

    function new();
      codes = '{RST_CODE_CALIBRATE, RST_CODE_THRESHOLD, RST_CODE_BUTTONS,
                RST_CODE_INTERRUPT, RST_CODE_LEVEL_READ};
      timeout   = RST_TIMEOUT_TICKS;
      wr_ptr    = '0;
      rd_ptr    = '0;
      held      = 0;
      in_frame  = 1'b0;
      remaining = '0;
      ready     = '0;
      timer_on  = 1'b0;
      timer     = '0;
      errors    = 0;
    endfunction

    function void set_register(cfg_reg_e idx, logic [TICK_W-1:0] value);
      if (idx == REG_TIMEOUT_TICKS) begin
        timeout = value;
      end else begin
        codes[idx] = value[BYTE_W-1:0];
      end
    endfunction

    // first match wins when codes overlap
    function logic [REM_W-1:0] payload_len(logic [BYTE_W-1:0] b);
      if (b == codes[REG_CODE_CALIBRATE]) return LEN_CALIBRATE;
      if (b == codes[REG_CODE_THRESHOLD]) return LEN_THRESHOLD;
      if (b == codes[REG_CODE_BUTTONS]) return LEN_BUTTONS;
      if (b == codes[REG_CODE_INTERRUPT]) return LEN_INTERRUPT;
      return '0;
    endfunction

    function bit push(logic [BYTE_W-1:0] b);
      if (held >= QUEUE_DEPTH) return 1'b0;
      store[wr_ptr] = b;
      wr_ptr = (wr_ptr == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      held++;
      return 1'b1;
    endfunction

    function logic [BYTE_W-1:0] pop();
      logic [BYTE_W-1:0] b;
      b = store[rd_ptr];
      rd_ptr = (rd_ptr == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      held--;
      return b;
    endfunction

    function void bump_ready();
      if (ready != READY_MAX) ready++;
    endfunction

    function void take_item(action_e act, logic [BYTE_W-1:0] rx);
      framer_status_t   s;
      logic [REM_W-1:0] len;
      logic [BYTE_W-1:0] lo;
      logic [BYTE_W-1:0] hi;
      s = '0;
      case (act)
        ACT_RX: begin
          if (in_frame) begin
            timer = '0;
            if (!push(rx)) begin
              s.byte_dropped = 1'b1;
            end else begin
              remaining = remaining - 1'b1;
              if (remaining == '0) begin
                timer_on = 1'b0;
                in_frame = 1'b0;
                bump_ready();
              end
            end
          end else begin
            len = payload_len(rx);
            if (len != '0) begin
              if (push(rx)) begin
                in_frame  = 1'b1;
                remaining = len;
                timer     = '0;
                timer_on  = 1'b1;
              end else begin
                s.byte_dropped = 1'b1;
              end
            end else if (rx == codes[REG_CODE_LEVEL_READ]) begin
              bump_ready();
            end else begin
              s.byte_dropped = 1'b1;
            end
          end
        end
        ACT_TICK: begin
          if (timer_on) begin
            timer = timer + 1'b1;
            if (timer >= timeout) begin
              timer_on  = 1'b0;
              timer     = '0;
              in_frame  = 1'b0;
              remaining = '0;
              ready     = '0;
              wr_ptr    = '0;
              rd_ptr    = '0;
              held      = 0;
              s.timed_out = 1'b1;
            end
          end
        end
        ACT_POP_BYTE: begin
          if (held >= 1) begin
            s.read_data = WORD_W'(pop());
            s.read_ok   = 1'b1;
          end
        end
        default: begin
          if (held >= 2) begin
            lo = pop();
            hi = pop();
            s.read_data = {hi, lo};
            s.read_ok   = 1'b1;
          end
        end
      endcase
      s.frames_ready = ready;
      s.receiving    = in_frame;
      s.queue_count  = CNT_W'(held);
      pending_status.push_back(s);
    endfunction

    function void compare_field(string name, logic [WORD_W-1:0] want_v,
                                logic [WORD_W-1:0] got_v);
      if (want_v !== got_v) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
        errors++;
      end
    endfunction

    function void check_status(framer_status_t got);
      framer_status_t want;
      if (pending_status.size() == 0) begin
        $display("%0t: result with no transaction pending, expected none, got %h",
                 $time, got);
        errors++;
        return;
      end
      want = pending_status.pop_front();
      compare_field("read_data", want.read_data, got.read_data);
      compare_field("read_ok", WORD_W'(want.read_ok), WORD_W'(got.read_ok));
      compare_field("frames_ready", WORD_W'(want.frames_ready), WORD_W'(got.frames_ready));
      compare_field("receiving", WORD_W'(want.receiving), WORD_W'(got.receiving));
      compare_field("queue_count", WORD_W'(want.queue_count), WORD_W'(got.queue_count));
      compare_field("timed_out", WORD_W'(want.timed_out), WORD_W'(got.timed_out));
      compare_field("byte_dropped", WORD_W'(want.byte_dropped), WORD_W'(got.byte_dropped));
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           action_i = ACT_RX;
  logic [BYTE_W-1:0]    rx_byte_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [WORD_W-1:0]    read_data_o;
  logic                 read_ok_o;
  logic [READY_W-1:0]   frames_ready_o;
  logic                 receiving_o;
  logic [CNT_W-1:0]     queue_count_o;
  logic                 timed_out_o;
  logic                 byte_dropped_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [TICK_W-1:0]    cfg_data_i = '0;

  framer_tracker tracker;
  int            send_gap_pct = 29;
  int            recv_stall_pct = 62;
  int            items_sent = 0;

  uart_command_framer_queue DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .read_data_o   (read_data_o),
    .read_ok_o     (read_ok_o),
    .frames_ready_o(frames_ready_o),
    .receiving_o   (receiving_o),
    .queue_count_o (queue_count_o),
    .timed_out_o   (timed_out_o),
    .byte_dropped_o(byte_dropped_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        tracker.take_item(action_e'(action_i), rx_byte_i);
      end
      if (out_valid_o && !out_stall_i) begin
        tracker.check_status(framer_status_t'{read_data_o, read_ok_o, frames_ready_o,
                                              receiving_o, queue_count_o, timed_out_o,
                                              byte_dropped_o});
      end
    end
  end

  task automatic send(action_e act, logic [BYTE_W-1:0] b);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  // wait for every pending transaction result, then let the pipeline empty
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending_status.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_settings(logic [BYTE_W-1:0] cal, logic [BYTE_W-1:0] thr,
                                logic [BYTE_W-1:0] btn, logic [BYTE_W-1:0] intr,
                                logic [BYTE_W-1:0] lvl, logic [TICK_W-1:0] tmo);
    logic [TICK_W-1:0] vals [6];
    cfg_reg_e          r = REG_CODE_CALIBRATE;
    vals[REG_CODE_CALIBRATE]  = TICK_W'(cal);
    vals[REG_CODE_THRESHOLD]  = TICK_W'(thr);
    vals[REG_CODE_BUTTONS]    = TICK_W'(btn);
    vals[REG_CODE_INTERRUPT]  = TICK_W'(intr);
    vals[REG_CODE_LEVEL_READ] = TICK_W'(lvl);
    vals[REG_TIMEOUT_TICKS]   = tmo;
    repeat (r.num()) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= r;
      cfg_data_i  <= vals[r];
      @(posedge clk_i);
      tracker.set_register(r, vals[r]);
      r = r.next();
    end
    cfg_we_i <= 1'b0;
  endtask

  // mostly well-formed frames with random payload, plus pops, ticks and noise
  task automatic run_random(int count, int read_cmd_pct);
    int                stop_at;
    int                pick;
    int                len;
    int                keep;
    int                tick_max;
    logic [BYTE_W-1:0] code;
    stop_at  = items_sent + count;
    tick_max = (tracker.timeout < 20) ? int'(tracker.timeout) + 2 : 20;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < read_cmd_pct) begin
        repeat ($urandom_range(1, 24)) send(ACT_RX, tracker.codes[REG_CODE_LEVEL_READ]);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          code = tracker.codes[cfg_reg_e'($urandom_range(REG_CODE_CALIBRATE,
                                                         REG_CODE_INTERRUPT))];
          len  = int'(tracker.payload_len(code));
          keep = ($urandom_range(0, 99) < 8) ? $urandom_range(0, len - 1) : len;
          send(ACT_RX, code);
          repeat (keep) begin
            if ($urandom_range(0, 9) == 0) begin
              send(action_e'($urandom_range(ACT_TICK, ACT_POP_WORD)), 8'($urandom));
            end
            send(ACT_RX, 8'($urandom_range(0, 255)));
          end
        end else if (pick < 75) begin
          repeat ($urandom_range(1, 12)) begin
            send(($urandom_range(0, 1) != 0) ? ACT_POP_BYTE : ACT_POP_WORD, 8'($urandom));
          end
        end else if (pick < 88) begin
          repeat ($urandom_range(1, tick_max)) send(ACT_TICK, 8'($urandom));
        end else begin
          repeat ($urandom_range(1, 3)) begin
            send(action_e'($urandom_range(ACT_RX, ACT_POP_WORD)), 8'($urandom));
          end
        end
      end
    end
  endtask

  initial begin
    tracker = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_settings(8'h00, 8'hFF, 8'h03, 8'h04, 8'h05, 16'd3);
    send(ACT_POP_BYTE, 8'h00);
    send(ACT_POP_WORD, 8'hFF);
    send(ACT_TICK, 8'h00);
    send(ACT_RX, 8'hAA);
    send(ACT_RX, 8'h05);
    send(ACT_RX, 8'hFF);
    send(ACT_RX, 8'h00);
    send(ACT_TICK, 8'hFF);
    send(ACT_RX, 8'hFF);
    send(ACT_RX, 8'h5A);
    send(ACT_RX, 8'hA5);
    send(ACT_POP_WORD, 8'h00);
    send(ACT_POP_BYTE, 8'h00);
    send(ACT_POP_WORD, 8'h00);
    send(ACT_RX, 8'h04);
    repeat (3) send(ACT_TICK, 8'h00);
    send(ACT_RX, 8'h00);
    send(ACT_RX, 8'h33);
    send(ACT_POP_WORD, 8'h00);
    repeat (3) send(ACT_TICK, 8'h00);
    send(ACT_RX, 8'h03);
    settle();

    write_settings(RST_CODE_CALIBRATE, RST_CODE_THRESHOLD, RST_CODE_BUTTONS,
                   RST_CODE_INTERRUPT, RST_CODE_LEVEL_READ, RST_TIMEOUT_TICKS);
    run_random(200, 8);
    settle();
    write_settings(8'h00, 8'hFF, 8'h80, 8'h7F, 8'h40, 16'd1);
    run_random(200, 8);
    settle();

    send_gap_pct   = 62;
    recv_stall_pct = 29;
    // overlapping codes, level read shadowed by the interrupt code
    write_settings(8'h09, 8'h09, 8'h09, 8'hC8, 8'hC8, 16'd5);
    run_random(200, 8);
    settle();
    // long timeout and many read commands to saturate frames ready
    write_settings(8'hFF, 8'h00, 8'hAA, 8'h55, 8'h80, 16'hFFFF);
    run_random(400, 55);
    settle();

    send_gap_pct   = 0;
    recv_stall_pct = 0;
    write_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   16'($urandom_range(2, 40)));
    run_random(200, 8);
    settle();
    write_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'h00, 16'd12);
    run_random(200, 8);
    settle();

    if (tracker.errors == 0) begin
      $display("uart_command_framer_queue test passed");
    end else begin
      $display("uart_command_framer_queue test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("uart_command_framer_queue test failed");
    $finish;
  end

endmodule

@@ sim.f @@
design/ucfq_pkg.sv
design/ucfq_ram.sv
design/ucfq_dp.sv
design/ucfq_ctrl.sv
design/uart_command_framer_queue.sv
tb/tb.sv
